FILE: rtl/lzfd_pkg.sv
// shared types and constants of the lzss flag-byte decompressor
// used by every module under rtl except lzfd_ram; depends on nothing

package lzfd_pkg;

  localparam int unsigned WinDepth    = 4096;
  localparam int unsigned WinAw       = $clog2(WinDepth);
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned HdrIdxW     = 3;
  localparam int unsigned HdrLenIdx   = 1;
  localparam int unsigned MinMatch    = 3;
  localparam int unsigned FlagBits    = 8;
  localparam int unsigned FlagPosW    = 4;
  localparam int unsigned LenW        = 5;
  localparam int unsigned MaxMatch    = 15 + MinMatch;
  localparam int unsigned QueueDepth  = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic [7:0] bytes_out;
  } out_t;

  typedef enum logic {
    TokLiteral,
    TokMatch
  } tok_e;

  // arg: literal byte in the low bits, or the 12-bit distance field
  typedef struct packed {
    tok_e             kind;
    logic [WinAw-1:0] arg;
    logic [LenW-1:0]  len;
    logic [7:0]       base;
    logic [7:0]       target;
  } cmd_t;

  typedef enum logic [1:0] {
    BkClear,
    BkIdle,
    BkRun
  } bk_state_e;

endpackage

FILE: rtl/lzfd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module lzfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lzfd_front.sv
// front end: header, flag and token parsing, output length bookkeeping
// depends on lzfd_pkg; pushes one command per literal or match

module lzfd_front import lzfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  input  logic hold_i,
  input  logic full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  logic [HdrIdxW-1:0]  hdr_q, hdr_d;
  logic [7:0]          tgt_q, tgt_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [7:0]          flags_q, flags_d;
  logic [FlagPosW-1:0] fpos_q, fpos_d;
  logic [7:0]          mfb_q, mfb_d;
  logic                aw_q, aw_d;

  logic                accept;
  logic [HdrIdxW-1:0]  hdr_e;
  logic [7:0]          cnt_e;
  logic [FlagPosW-1:0] fpos_e;
  logic [7:0]          mfb_e;
  logic                aw_e;
  logic [LenW-1:0]     mlen;
  logic [7:0]          remain;
  logic [LenW-1:0]     elen;
  logic                flag_bit;

  assign in_ready_o = !full_i && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  // frame start aborts the frame in progress
  always_comb begin
    hdr_e  = in_i.frame_start ? '0 : hdr_q;
    cnt_e  = in_i.frame_start ? '0 : cnt_q;
    fpos_e = in_i.frame_start ? FlagPosW'(FlagBits) : fpos_q;
    mfb_e  = in_i.frame_start ? '0 : mfb_q;
    aw_e   = in_i.frame_start ? 1'b0 : aw_q;
  end

  assign flag_bit = flags_q[~fpos_e[2:0]];
  assign mlen     = LenW'({1'b0, mfb_e[7:4]}) + LenW'(MinMatch);
  assign remain   = tgt_q - cnt_e;
  assign elen     = (8'(mlen) < remain) ? mlen : remain[LenW-1:0];

  always_comb begin
    hdr_d   = hdr_q;
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    flags_d = flags_q;
    fpos_d  = fpos_q;
    mfb_d   = mfb_q;
    aw_d    = aw_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: TokLiteral, arg: WinAw'(in_i.in_byte), len: LenW'(1),
                base: cnt_e, target: tgt_q};
    if (accept) begin
      hdr_d  = hdr_e;
      cnt_d  = cnt_e;
      fpos_d = fpos_e;
      mfb_d  = mfb_e;
      aw_d   = aw_e;
      priority if (hdr_e < HdrIdxW'(HeaderBytes)) begin
        if (hdr_e == HdrIdxW'(HdrLenIdx)) begin
          tgt_d = in_i.in_byte;
        end
        hdr_d = hdr_e + 1'b1;
      end else if (cnt_e == tgt_q) begin
        // frame done, byte dropped
      end else if (fpos_e >= FlagPosW'(FlagBits)) begin
        flags_d = in_i.in_byte;
        fpos_d  = '0;
      end else if (!flag_bit) begin
        push_o = 1'b1;
        cnt_d  = cnt_e + 1'b1;
        fpos_d = fpos_e + 1'b1;
      end else if (!aw_e) begin
        mfb_d = in_i.in_byte;
        aw_d  = 1'b1;
      end else begin
        push_o     = 1'b1;
        cmd_o.kind = TokMatch;
        cmd_o.arg  = {mfb_e[3:0], in_i.in_byte};
        cmd_o.len  = elen;
        cnt_d      = cnt_e + 8'(elen);
        aw_d       = 1'b0;
        fpos_d     = fpos_e + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      tgt_q   <= '0;
      cnt_q   <= '0;
      flags_q <= '0;
      fpos_q  <= FlagPosW'(FlagBits);
      mfb_q   <= '0;
      aw_q    <= 1'b0;
    end else begin
      hdr_q   <= hdr_d;
      tgt_q   <= tgt_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
      fpos_q  <= fpos_d;
      mfb_q   <= mfb_d;
      aw_q    <= aw_d;
    end
  end

  a_push_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.len != '0) && (cmd_o.len <= LenW'(MaxMatch)))
    else $error("command with bad length");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q == HdrIdxW'(HeaderBytes)) |-> (cnt_q <= tgt_q))
    else $error("output count passed expected length");

endmodule

FILE: rtl/lzfd_queue.sv
// small command queue between front end and copy engine
// depends on lzfd_pkg

module lzfd_queue import lzfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lzfd_back.sv
// copy engine: history window, literal and match output, output register
// depends on lzfd_pkg and lzfd_ram; clears the window after reset

module lzfd_back import lzfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic clearing_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  bk_state_e        state_q, state_d;
  logic [WinAw-1:0] clr_addr_q;
  cmd_t             cur_q;
  logic [LenW-1:0]  k_q;
  logic [WinAw-1:0] src_q;
  logic [WinAw-1:0] wp_q;
  logic             pend_q;
  logic             byp_q;
  logic [7:0]       byp_data_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             slot_free;
  logic             load;
  logic             start;
  logic [7:0]       data;
  logic [LenW-1:0]  k_next;
  logic             last;
  logic [WinAw-1:0] first_src;
  logic             ram_we, ram_re;
  logic [WinAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  lzfd_ram #(
    .Width(8),
    .Depth(WinDepth)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkClear: begin
        if (clr_addr_q == '1) state_d = BkIdle;
      end
      BkIdle: begin
        if (cmd_valid_i) state_d = BkRun;
      end
      BkRun: begin
        if (load && last) state_d = BkIdle;
      end
      default: state_d = BkClear;
    endcase
  end

  always_comb begin
    slot_free = !out_valid_q || out_ready_i;
    load      = (state_q == BkRun) && pend_q && slot_free;
    start     = (state_q == BkIdle) && cmd_valid_i;
    k_next    = k_q + 1'b1;
    last      = (k_next == cur_q.len);
    first_src = wp_q - cmd_i.arg - 1'b1;
    if (cur_q.kind == TokLiteral) begin
      data = cur_q.arg[7:0];
    end else if (byp_q) begin
      data = byp_data_q;
    end else begin
      data = ram_rdata;
    end
    pop_o      = start;
    clearing_o = (state_q == BkClear);
    ram_we     = clearing_o || load;
    ram_waddr  = clearing_o ? clr_addr_q : wp_q;
    ram_wdata  = clearing_o ? 8'h00 : data;
    ram_re     = (start && (cmd_i.kind == TokMatch))
               || (load && !last && (cur_q.kind == TokMatch));
    ram_raddr  = start ? first_src : src_q;
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= cmd_i;
      src_q <= first_src + 1'b1;
    end else if (load) begin
      src_q      <= src_q + 1'b1;
      byp_data_q <= data;
    end
    if (load) begin
      out_q <= '{out_byte: data, run_last: last,
                 frame_done: (cur_q.base + 8'(k_next)) == cur_q.target,
                 bytes_out: cur_q.base + 8'(k_next)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkClear;
      clr_addr_q  <= '0;
      wp_q        <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_o) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (start) begin
        k_q    <= '0;
        pend_q <= 1'b1;
        byp_q  <= 1'b0;
      end else if (load) begin
        k_q   <= k_next;
        wp_q  <= wp_q + 1'b1;
        // next read hits the entry written this cycle
        byp_q <= (src_q == wp_q);
        if (last) begin
          pend_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_pend_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == BkRun))
    else $error("pending window read outside run");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkRun) |-> (k_q < cur_q.len))
    else $error("copy ran past command length");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkClear) |-> !out_valid_q && !pend_q)
    else $error("output during window clear");

endmodule

FILE: rtl/lzss_flag_byte_decompressor_top.sv
// top level of the lzss flag-byte decompressor: front end, queue, copy engine
// depends on lzfd_pkg, lzfd_front, lzfd_queue, lzfd_back
//
//   channel  handshake               payload  moves
//   in       in_valid_i / in_ready_o in_i     one compressed byte per request
//   out      out_valid_o/out_ready_i out_o    one decoded byte per request
//
// the copy engine writes out a literal as one byte and a match of n bytes as n bytes
// (up to 18), one byte per cycle through the window ram read port unless the output stalls
// after reset all 4096 window entries are cleared, with in_ready_o low
// header, flag and first match bytes give no output
// a two-entry command queue lets the front end parse while a copy runs

module lzss_flag_byte_decompressor_top import lzfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic q_push, q_full, q_pop, q_valid, clearing;
  cmd_t push_cmd, head_cmd;

  lzfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i      (in_i),
    .hold_i    (clearing),
    .full_i    (q_full),
    .push_o    (q_push),
    .cmd_o     (push_cmd)
  );

  lzfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  lzfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (q_pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule
